/* hdl/dahs_pkg.sv */
// Shared types and constants for the dirty area histogram statistics block.
package dahs_pkg;

  // Field widths
  localparam int DIM_W      = 13;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int REASON_W   = 64;
  localparam int DB_W       = 6;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 64;
  localparam int BIN_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Top reason bit: its mask covers every bit from here up to the MSB
  localparam int SIGN_BIT = 31;
  localparam int DB_TOP   = 32;

  // Rounding of the bin index, and divide-by-ten via reciprocal
  localparam int ROUND_SCALE = 10;
  localparam int ROUND_HALF  = 5;
  localparam int RECIP_10    = 205;
  localparam int RECIP_SHIFT = 11;
  localparam int RX_W        = 11;
  localparam int RPROD_W     = 22;

  // Register reset values
  localparam logic             RST_ENABLE      = 1'b0;
  localparam logic [DIM_W-1:0] RST_SCREEN_W    = 13'd1080;
  localparam logic [DIM_W-1:0] RST_SCREEN_H    = 13'd2400;
  localparam logic [DB_W-1:0]  RST_DISABLE_BIT = 6'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_SKIP      = 3'd1,
    ST_OFF       = 3'd2,
    ST_ZERO_AREA = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_SCREEN_W    = 2'd1,
    CFG_SCREEN_H    = 2'd2,
    CFG_DISABLE_BIT = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCALE,
    S_DIV,
    S_BIN,
    S_INC_RD,
    S_INC_WR,
    S_EMIT,
    S_RD_FRAME,
    S_RD_MEM
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    check;
    logic    count_frame;
    logic    set_status;
    status_t status_code;
    logic    scale;
    logic    div_step;
    logic    bin;
    logic    mem_rd;
    logic    mem_inc;
    logic    emit_frame;
    logic    sweep_start;
    logic    sweep_step;
    logic    clear_all;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enabled;
    logic skip;
    logic reason_zero;
    logic reason_hit;
    logic full_zero;
    logic out_of_range;
    logic div_last;
    logic sweep_last;
  } stat_t;

endpackage

/* hdl/dirty_area_histogram_stats.sv */
// A frame event gives a single result, registered from the S_EMIT state; area bins take longest,
// as they pass the bit-serial divider of NUM_W steps (34 at 25 bins).
// A read puts 1+AREA_BINS+REASON_BITS results on consecutive cycles, the first registered from
// the S_RD_FRAME state, one counter memory read per cycle; busy is high until the last is out.
// A new command is taken only while busy is low, after a frame or a read has finished.
// Results cannot be stalled. Reset: synchronous, clears counters and config.
module dirty_area_histogram_stats import dahs_pkg::*; #(
  parameter int AREA_BINS   = 25,
  parameter int REASON_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode,
  input  logic [DIM_W-1:0]      dirty_width,
  input  logic [DIM_W-1:0]      dirty_height,
  input  logic [REASON_W-1:0]   reason,
  output logic                  strobe,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_W-1:0]     slot,
  output logic [COUNT_W-1:0]    count,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  dahs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  dahs_datapath #(
    .AREA_BINS   (AREA_BINS),
    .REASON_BITS (REASON_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .dirty_width  (dirty_width),
    .dirty_height (dirty_height),
    .reason       (reason),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .status       (status),
    .slot         (slot),
    .count        (count),
    .last         (last)
  );

endmodule

/* hdl/dahs_ctrl.sv */
// Sequencing state machine for frame events and counter reads.
module dahs_ctrl import dahs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  opcode,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (opcode == OP_READ) ? S_RD_FRAME : S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.enabled || stat.skip) begin
          state_next = S_EMIT;
        end else if (stat.reason_zero) begin
          state_next = S_SCALE;
        end else if (stat.reason_hit) begin
          state_next = S_INC_RD;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SCALE: begin
        state_next = stat.full_zero ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        if (stat.div_last) begin
          state_next = S_BIN;
        end
      end
      S_BIN: begin
        state_next = stat.out_of_range ? S_EMIT : S_INC_RD;
      end
      S_INC_RD:   state_next = S_INC_WR;
      S_INC_WR:   state_next = S_EMIT;
      S_EMIT:     state_next = S_IDLE;
      S_RD_FRAME: state_next = S_RD_MEM;
      S_RD_MEM: begin
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd             = '0;
    cmd.status_code = ST_OK;
    busy            = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_CHECK: begin
        cmd.check      = 1'b1;
        cmd.set_status = 1'b1;
        if (!stat.enabled) begin
          cmd.status_code = ST_OFF;
        end else if (stat.skip) begin
          cmd.status_code = ST_SKIP;
        end else begin
          cmd.count_frame = 1'b1;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        if (stat.full_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_ZERO_AREA;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_BIN: begin
        if (stat.out_of_range) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_RANGE;
        end else begin
          cmd.bin = 1'b1;
        end
      end
      S_INC_RD:   cmd.mem_rd = 1'b1;
      S_INC_WR:   cmd.mem_inc = 1'b1;
      S_EMIT:     cmd.emit_frame = 1'b1;
      S_RD_FRAME: cmd.sweep_start = 1'b1;
      S_RD_MEM: begin
        cmd.sweep_step = 1'b1;
        cmd.clear_all  = stat.sweep_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // An accepted beat always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && start |=> (state == S_CHECK) || (state == S_RD_FRAME))
    else $error("accepted beat did not start work");

  // The read sweep runs until its final entry
  a_sweep_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD_MEM) && !stat.sweep_last |=> (state == S_RD_MEM))
    else $error("read sweep ended early");

endmodule

/* hdl/dahs_datapath.sv */
// Datapath: configuration, counters, area divider and counter memory.
module dahs_datapath import dahs_pkg::*; #(
  parameter int AREA_BINS   = 25,
  parameter int REASON_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [DIM_W-1:0]      dirty_width,
  input  logic [DIM_W-1:0]      dirty_height,
  input  logic [REASON_W-1:0]   reason,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  strobe,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_W-1:0]     slot,
  output logic [COUNT_W-1:0]    count,
  output logic                  last
);

  localparam int ENTRIES   = AREA_BINS + REASON_BITS;
  localparam int MEM_AW    = $clog2(ENTRIES);
  localparam int SCALE_K   = ROUND_SCALE * (AREA_BINS - 1);
  localparam int NUM_W     = AREA_W + $clog2(SCALE_K);
  localparam int DCNT_W    = $clog2(NUM_W);
  localparam int RIDX_W    = (REASON_BITS > 1) ? $clog2(REASON_BITS) : 1;
  localparam int RANGE_LIM = ROUND_SCALE * AREA_BINS - ROUND_HALF;

  // Configuration registers
  logic              enable_q;
  logic [DIM_W-1:0]  screen_w;
  logic [DIM_W-1:0]  screen_h;
  logic [DB_W-1:0]   disable_bit;

  // Latched input beat
  logic [DIM_W-1:0]    w_q;
  logic [DIM_W-1:0]    h_q;
  logic [REASON_W-1:0] reason_q;

  // Arithmetic
  logic [AREA_W-1:0] wh;
  logic [AREA_W-1:0] full;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  quo;
  logic [AREA_W-1:0] rem;
  logic [DCNT_W-1:0] dcnt;
  logic [AREA_W:0]   trial;
  logic              trial_ge;
  logic [RX_W-1:0]   rx;
  logic [RPROD_W-1:0] rprod;
  logic [MEM_AW-1:0] bin_idx;

  // Reason decode
  logic                   top_any;
  logic [REASON_BITS-1:0] eff;
  logic                   hit;
  logic [RIDX_W-1:0]      hit_idx;
  logic                   skip;
  logic [DB_W-1:0]        db_m1;

  // Counters and memory
  logic [COUNT_W-1:0] frame_total;
  status_t            status_q;
  logic [MEM_AW-1:0]  addr;
  logic [MEM_AW-1:0]  ptr;
  logic [BIN_W-1:0]   mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [BIN_W-1:0]   rdata;
  logic               rvalid;
  logic [MEM_AW-1:0]  raddr;
  logic               mem_re;
  logic [BIN_W-1:0]   entry_val;
  logic               sweep_last;
  logic [31:0]        slot_wide;

  // Accept configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_q    <= RST_ENABLE;
      screen_w    <= RST_SCREEN_W;
      screen_h    <= RST_SCREEN_H;
      disable_bit <= RST_DISABLE_BIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:      enable_q    <= cfg_data[0];
        CFG_SCREEN_W:    screen_w    <= cfg_data;
        CFG_SCREEN_H:    screen_h    <= cfg_data;
        CFG_DISABLE_BIT: disable_bit <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_q      <= dirty_width;
      h_q      <= dirty_height;
      reason_q <= reason;
    end
  end

  // Effective reason bits; the top one folds in every higher bit
  always_comb begin
    top_any = |reason_q[REASON_W-1:SIGN_BIT];
    for (int j = 0; j < REASON_BITS; j++) begin
      eff[j] = (j < SIGN_BIT) ? reason_q[j] : top_any;
    end
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = REASON_BITS - 1; j >= 0; j--) begin
      if (eff[j]) begin
        hit     = 1'b1;
        hit_idx = RIDX_W'(j);
      end
    end
  end

  // Skip test against the one-based disable bit
  always_comb begin
    db_m1 = disable_bit - DB_W'(1);
    skip  = 1'b0;
    if (disable_bit == DB_W'(DB_TOP)) begin
      skip = top_any;
    end else if ((disable_bit != '0) && (disable_bit < DB_W'(DB_TOP))) begin
      skip = reason_q[db_m1[4:0]];
    end
  end

  // Restoring divider step
  assign trial    = {rem, num[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, full});

  // Round the quotient into a bin: (q + 5) / 10 by reciprocal
  assign rx      = RX_W'(quo[9:0]) + RX_W'(ROUND_HALF);
  assign rprod   = RPROD_W'(rx) * RPROD_W'(RECIP_10);
  assign bin_idx = MEM_AW'(rprod >> RECIP_SHIFT);

  // Area products, scaling and division
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      wh   <= AREA_W'(w_q) * AREA_W'(h_q);
      full <= AREA_W'(screen_w) * AREA_W'(screen_h);
    end
    if (cmd.scale) begin
      num  <= NUM_W'(wh) * NUM_W'(SCALE_K);
      quo  <= '0;
      rem  <= '0;
      dcnt <= DCNT_W'(NUM_W - 1);
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? AREA_W'(trial - {1'b0, full}) : trial[AREA_W-1:0];
      num  <= {num[NUM_W-2:0], 1'b0};
      quo  <= {quo[NUM_W-2:0], trial_ge};
      dcnt <= dcnt - DCNT_W'(1);
    end
  end

  // Target entry of the increment
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      addr <= MEM_AW'(AREA_BINS) + MEM_AW'(hit_idx);
    end else if (cmd.bin) begin
      addr <= bin_idx;
    end
  end

  // Frame count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      frame_total <= '0;
    end else if (cmd.count_frame) begin
      frame_total <= frame_total + COUNT_W'(1);
    end
  end

  // Frame result status
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_q <= ST_OK;
    end else if (cmd.set_status) begin
      status_q <= cmd.status_code;
    end
  end

  // Sweep pointer
  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      ptr <= '0;
    end else if (cmd.sweep_step) begin
      ptr <= ptr + MEM_AW'(1);
    end
  end

  assign sweep_last = (ptr == MEM_AW'(ENTRIES - 1));

  // Memory read address and enable
  always_comb begin
    raddr = addr;
    if (cmd.sweep_start) begin
      raddr = '0;
    end else if (cmd.sweep_step) begin
      raddr = ptr + MEM_AW'(1);
    end
    mem_re = cmd.mem_rd || cmd.sweep_start || (cmd.sweep_step && !sweep_last);
  end

  assign entry_val = rvalid ? rdata : '0;

  // Counter memory
  always_ff @(posedge clk) begin
    if (cmd.mem_inc) begin
      mem[addr] <= entry_val + BIN_W'(1);
    end
    if (mem_re) begin
      rdata  <= mem[raddr];
      rvalid <= valid[raddr];
    end
  end

  // Entry valid bits; drop them all after a read
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid <= '0;
    end else if (cmd.mem_inc) begin
      valid[addr] <= 1'b1;
    end
  end

  assign slot_wide = 32'(ptr) + 32'd1;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_frame || cmd.sweep_start || cmd.sweep_step;
    end
    if (cmd.emit_frame) begin
      status <= status_q;
      slot   <= '0;
      count  <= '0;
      last   <= 1'b1;
    end else if (cmd.sweep_start) begin
      status <= ST_OK;
      slot   <= '0;
      count  <= frame_total;
      last   <= 1'b0;
    end else if (cmd.sweep_step) begin
      status <= ST_OK;
      slot   <= slot_wide[SLOT_W-1:0];
      count  <= COUNT_W'(entry_val);
      last   <= sweep_last;
    end
  end

  assign stat.enabled      = enable_q;
  assign stat.skip         = skip;
  assign stat.reason_zero  = (reason_q == '0);
  assign stat.reason_hit   = hit;
  assign stat.full_zero    = (full == '0);
  assign stat.out_of_range = (quo >= NUM_W'(RANGE_LIM));
  assign stat.div_last     = (dcnt == '0);
  assign stat.sweep_last   = sweep_last;

  // An increment always follows its read
  a_inc_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_inc |-> $past(cmd.mem_rd))
    else $error("increment without preceding read");

  // Divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (rem < full))
    else $error("divider remainder out of bound");

  // A completed read leaves every entry cleared
  a_clear_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_all |=> (valid == '0) && (frame_total == '0))
    else $error("stores not cleared after read");

endmodule
